@@ design/sla_pkg.sv @@
// Shared types and character constants of the serial line input assembler.
package sla_pkg;

  localparam int FILL_W = 7;

  localparam logic [7:0] CH_DELETE = 8'h7F;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef enum logic [1:0] {
    OP_RX_BYTE = 2'd0,
    OP_ARM     = 2'd1,
    OP_READ    = 2'd2
  } op_e;

  typedef struct packed {
    logic              echo_valid;
    logic [7:0]        echo_byte;
    logic              line_full;
    logic              line_complete;
    logic [7:0]        read_data;
    logic [FILL_W-1:0] fill_level;
    logic              last;
  } result_t;

  typedef struct packed {
    logic wr_en;
    logic term_en;
    logic clr_all;
  } store_cmd_t;

endpackage

@@ design/sla_line_store.sv @@
// Line store memory with per-entry valid bits and a registered read port.
module sla_line_store #(
  parameter int LINE_DEPTH = 64,
  parameter int AW         = $clog2(LINE_DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sla_pkg::store_cmd_t cmd_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [7:0]          wdata_i,
  input  logic [AW-1:0]       taddr_i,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [7:0]          rdata_o
);
  import sla_pkg::*;

  logic [7:0]            mem [LINE_DEPTH];
  logic [LINE_DEPTH-1:0] valid_q;
  logic [7:0]            rdata_q;
  logic [AW-1:0]         raddr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // A write in the same cycle as the read is forwarded to the read data.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      raddr_q <= raddr_i;
      if (cmd_i.wr_en && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem[raddr_i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clr_all) begin
      valid_q <= '0;
    end else begin
      if (cmd_i.wr_en) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (cmd_i.term_en) begin
        valid_q[taddr_i] <= 1'b0;
      end
    end
  end

  assign rdata_o = valid_q[raddr_q] ? rdata_q : 8'h00;

endmodule

@@ design/sla_result_buffer.sv @@
// Result register with a second slot for steps that give two results.
module sla_result_buffer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  sla_pkg::result_t first_i,
  input  sla_pkg::result_t second_i,
  input  logic             two_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output sla_pkg::result_t out_o,
  output logic             free_o
);
  import sla_pkg::*;

  logic    out_v_q;
  logic    pend_v_q;
  result_t out_q;
  result_t pend_q;
  logic    out_take;

  assign out_take = out_v_q && !out_stall_i;
  assign free_o   = !pend_v_q && (!out_v_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else if (load_i) begin
      out_v_q  <= 1'b1;
      pend_v_q <= two_i;
    end else if (out_take) begin
      out_v_q  <= pend_v_q;
      pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      out_q  <= first_i;
      pend_q <= second_i;
    end else if (out_take && pend_v_q) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

@@ design/serial_line_input_assembler_top.sv @@
// Top level of the serial line input assembler with echo.
//
//   channel  valid        stall        payload
//   input    in_valid_i   in_stall_o   operation_i rx_byte_i frame_error_i read_index_i
//   output   out_valid_o  out_stall_i  echo_valid_o echo_byte_o line_full_o
//                                      line_complete_o read_data_o fill_level_o last_o
//
// An input transfer lands in the input register, then its results in the result register.
// One item a cycle is sustained while the output does not stall; a carriage return or line
// feed holds the input while the result register sends its two echo results one per cycle.
// Reset disarms reception, empties the line and clears all entry valid bits at once.
// A stalled output holds its result and, in the same cycle, the input.
module serial_line_input_assembler_top #(
  parameter int LINE_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_error_i,
  input  logic [5:0] read_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       echo_valid_o,
  output logic [7:0] echo_byte_o,
  output logic       line_full_o,
  output logic       line_complete_o,
  output logic [7:0] read_data_o,
  output logic [6:0] fill_level_o,
  output logic       last_o
);
  import sla_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int PW = $clog2(LINE_DEPTH + 1);

  logic          s1_v_q;
  logic [1:0]    s1_op_q;
  logic [7:0]    s1_ch_q;
  logic          s1_err_q;
  logic [5:0]    s1_idx_q;
  logic [PW-1:0] pos_q, pos_d;
  logic          armed_q, armed_d;

  logic          in_take;
  logic          adv;
  logic          out_free;
  store_cmd_t    st_cmd;
  logic [AW-1:0] taddr;
  logic [7:0]    store_rdata;
  logic          rd_ok;
  logic          two;
  logic          full;
  logic          done;
  logic [8:0]    pos_ext;
  result_t       r0, r1, out_res;

  assign adv        = s1_v_q && out_free;
  assign in_stall_o = s1_v_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;
  assign rd_ok      = {3'b000, s1_idx_q} < 9'(LINE_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      pos_q   <= '0;
      armed_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_v_q <= 1'b1;
      end else if (adv) begin
        s1_v_q <= 1'b0;
      end
      if (adv) begin
        pos_q   <= pos_d;
        armed_q <= armed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_op_q  <= operation_i;
      s1_ch_q  <= rx_byte_i;
      s1_err_q <= frame_error_i;
      s1_idx_q <= read_index_i;
    end
  end

  always_comb begin
    pos_d   = pos_q;
    armed_d = armed_q;
    st_cmd  = '0;
    taddr   = '0;
    r0      = '0;
    r1      = '0;
    two     = 1'b0;
    full    = 1'b0;
    done    = 1'b0;
    case (s1_op_q)
      OP_ARM: begin
        st_cmd.clr_all = 1'b1;
        pos_d          = '0;
        armed_d        = 1'b1;
      end
      OP_READ: begin
        r0.read_data = rd_ok ? store_rdata : 8'h00;
      end
      OP_RX_BYTE: begin
        if (armed_q && !s1_err_q) begin
          if (s1_ch_q == CH_DELETE) begin
            if (pos_q != '0) begin
              pos_d        = pos_q - PW'(1);
              r0.echo_valid = 1'b1;
              r0.echo_byte  = CH_DELETE;
            end
          end else begin
            if (pos_q < PW'(LINE_DEPTH)) begin
              st_cmd.wr_en = 1'b1;
              pos_d        = pos_q + PW'(1);
            end else begin
              armed_d = 1'b0;
              full    = 1'b1;
            end
            if (s1_ch_q == CH_CR) begin
              armed_d = 1'b0;
              done    = 1'b1;
              if (pos_d < PW'(LINE_DEPTH)) begin
                st_cmd.term_en = 1'b1;
                taddr          = pos_d[AW-1:0];
              end
            end
            if ((s1_ch_q == CH_CR) || (s1_ch_q == CH_LF)) begin
              two              = 1'b1;
              r0.echo_valid    = 1'b1;
              r0.echo_byte     = (s1_ch_q == CH_CR) ? CH_LF : CH_CR;
              r1.echo_valid    = 1'b1;
              r1.echo_byte     = s1_ch_q;
              r1.line_full     = full;
              r1.line_complete = done;
            end else begin
              r0.echo_valid    = 1'b1;
              r0.echo_byte     = s1_ch_q;
              r0.line_full     = full;
              r0.line_complete = done;
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (!adv) begin
      st_cmd = '0;
    end
    pos_ext       = 9'(pos_d);
    r0.fill_level = pos_ext[FILL_W-1:0];
    r1.fill_level = pos_ext[FILL_W-1:0];
    r0.last       = !two;
    r1.last       = 1'b1;
  end

  sla_line_store #(
    .LINE_DEPTH (LINE_DEPTH),
    .AW         (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (st_cmd),
    .waddr_i (pos_q[AW-1:0]),
    .wdata_i (s1_ch_q),
    .taddr_i (taddr),
    .rd_en_i (in_take),
    .raddr_i (AW'(read_index_i)),
    .rdata_o (store_rdata)
  );

  sla_result_buffer u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv),
    .first_i     (r0),
    .second_i    (r1),
    .two_i       (two),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_res),
    .free_o      (out_free)
  );

  assign echo_valid_o    = out_res.echo_valid;
  assign echo_byte_o     = out_res.echo_byte;
  assign line_full_o     = out_res.line_full;
  assign line_complete_o = out_res.line_complete;
  assign read_data_o     = out_res.read_data;
  assign fill_level_o    = out_res.fill_level;
  assign last_o          = out_res.last;

endmodule

@@ tb/serial_line_input_assembler_checker.sv @@
// Checker of the serial line input assembler: predicts and compares every transfer.
module serial_line_input_assembler_checker #(
  parameter int LINE_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [1:0] operation_i,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_error_i,
  input  logic [5:0] read_index_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       echo_valid_i,
  input  logic [7:0] echo_byte_i,
  input  logic       line_full_i,
  input  logic       line_complete_i,
  input  logic [7:0] read_data_i,
  input  logic [6:0] fill_level_i,
  input  logic       last_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import sla_pkg::*;

  logic [7:0]  line_copy [LINE_DEPTH];
  int unsigned line_pos;
  bit          line_armed;
  result_t     expected_line_results [$];
  result_t     want_result;
  int          mismatch_count = 0;
  int          pending_count = 0;

  assign fail_count_o = mismatch_count;
  assign pending_o    = pending_count;

  function automatic void clear_line();
    foreach (line_copy[i]) line_copy[i] = 8'h00;
    line_pos = 0;
  endfunction

  function automatic void expect_result(logic echo, logic [7:0] ch, logic full, logic done,
                                        logic [7:0] rd, logic fin);
    result_t r;
    r.echo_valid    = echo;
    r.echo_byte     = echo ? ch : 8'h00;
    r.line_full     = full;
    r.line_complete = done;
    r.read_data     = rd;
    r.fill_level    = line_pos[FILL_W-1:0];
    r.last          = fin;
    expected_line_results.push_back(r);
  endfunction

  function automatic void assemble_line_results(logic [1:0] op, logic [7:0] ch, logic err,
                                                logic [5:0] idx);
    logic full;
    logic done;
    logic erased;
    full = 1'b0;
    done = 1'b0;
    if (op == OP_ARM) begin
      clear_line();
      line_armed = 1'b1;
      expect_result(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
    end else if (op == OP_READ) begin
      expect_result(1'b0, 8'h00, 1'b0, 1'b0, (idx < LINE_DEPTH) ? line_copy[idx] : 8'h00, 1'b1);
    end else if (op != OP_RX_BYTE || !line_armed || err) begin
      expect_result(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
    end else if (ch == CH_DELETE) begin
      erased = (line_pos > 0);
      if (erased) line_pos--;
      expect_result(erased, ch, 1'b0, 1'b0, 8'h00, 1'b1);
    end else begin
      if (line_pos < LINE_DEPTH) begin
        line_copy[line_pos] = ch;
        line_pos++;
      end else begin
        line_armed = 1'b0;
        full = 1'b1;
      end
      if (ch == CH_CR) begin
        line_armed = 1'b0;
        if (line_pos < LINE_DEPTH) line_copy[line_pos] = 8'h00;
        done = 1'b1;
      end
      if (ch == CH_CR || ch == CH_LF) begin
        expect_result(1'b1, (ch == CH_CR) ? CH_LF : CH_CR, 1'b0, 1'b0, 8'h00, 1'b0);
      end
      expect_result(1'b1, ch, full, done, 8'h00, 1'b1);
    end
  endfunction

  function automatic void check_field(string field_name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field_name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_line();
      line_armed = 1'b0;
      expected_line_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_line_results.size() == 0) begin
          $error("result transfer with nothing expected: echo_byte %0h", echo_byte_i);
          mismatch_count++;
        end else begin
          want_result = expected_line_results.pop_front();
          check_field("echo_valid", want_result.echo_valid, echo_valid_i);
          check_field("echo_byte", want_result.echo_byte, echo_byte_i);
          check_field("line_full", want_result.line_full, line_full_i);
          check_field("line_complete", want_result.line_complete, line_complete_i);
          check_field("read_data", want_result.read_data, read_data_i);
          check_field("fill_level", want_result.fill_level, fill_level_i);
          check_field("last", want_result.last, last_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        assemble_line_results(operation_i, rx_byte_i, frame_error_i, read_index_i);
      end
    end
    pending_count = expected_line_results.size();
  end

endmodule

@@ tb/tb_serial_line_input_assembler_top.sv @@
// Testbench top of the serial line input assembler: clock, reset, stimulus and verdict.
module tb_serial_line_input_assembler_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sla_pkg::*;

  localparam int         LINE_DEPTH        = 64;
  localparam int         CLK_PERIOD        = 4;
  localparam logic [1:0] OP_UNUSED         = 2'd3;
  localparam int         STALL_HOLD_CYCLES = 120;
  localparam int         WATCHDOG_LIMIT    = 2000;
  localparam int         DRAIN_CYCLES      = 8;
  localparam int         TARGET_ITEMS      = 1200;
  localparam int         QUIET_FROM_ITEM   = 1050;
  localparam int         HOLD_AT_ITEM      = 400;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] operation;
  logic [7:0] rx_byte;
  logic       frame_error;
  logic [5:0] read_index;
  logic       out_valid;
  logic       out_stall;
  logic       echo_valid;
  logic [7:0] echo_byte;
  logic       line_full;
  logic       line_complete;
  logic [7:0] read_data;
  logic [6:0] fill_level;
  logic       last;

  int          fail_count;
  int          pending_results;
  int          items_sent = 0;
  int          idle_cycles = 0;
  int unsigned line_length;
  bit          sender_idles = 1'b1;
  bit          receiver_stalls = 1'b1;
  bit          hold_request = 1'b0;
  bit          hold_done = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  serial_line_input_assembler_top #(
    .LINE_DEPTH(LINE_DEPTH)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (operation),
    .rx_byte_i      (rx_byte),
    .frame_error_i  (frame_error),
    .read_index_i   (read_index),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .echo_valid_o   (echo_valid),
    .echo_byte_o    (echo_byte),
    .line_full_o    (line_full),
    .line_complete_o(line_complete),
    .read_data_o    (read_data),
    .fill_level_o   (fill_level),
    .last_o         (last)
  );

  serial_line_input_assembler_checker #(
    .LINE_DEPTH(LINE_DEPTH)
  ) line_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .operation_i    (operation),
    .rx_byte_i      (rx_byte),
    .frame_error_i  (frame_error),
    .read_index_i   (read_index),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .echo_valid_i   (echo_valid),
    .echo_byte_i    (echo_byte),
    .line_full_i    (line_full),
    .line_complete_i(line_complete),
    .read_data_i    (read_data),
    .fill_level_i   (fill_level),
    .last_i         (last),
    .fail_count_o   (fail_count),
    .pending_o      (pending_results)
  );

  task automatic send_item(logic [1:0] op, logic [7:0] ch, logic err, logic [5:0] idx,
                           bit counted);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    rx_byte     <= ch;
    frame_error <= err;
    read_index  <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (counted) items_sent++;
  endtask

  function automatic logic [7:0] pick_line_char(bit plain);
    logic [7:0] ch;
    if (plain) return 8'($urandom_range(8'h20, 8'h7E));
    case ($urandom_range(0, 19))
      0, 1:    ch = CH_DELETE;
      2:       ch = CH_LF;
      3:       ch = CH_CR;
      4, 5:    ch = 8'($urandom_range(0, 255));
      default: ch = 8'($urandom_range(8'h20, 8'h7E));
    endcase
    return ch;
  endfunction

  task automatic run_line_session(int unsigned char_count, bit plain, bit end_with_cr);
    send_item(OP_ARM, 8'($urandom), 1'($urandom), 6'($urandom), 1'b1);
    repeat (char_count) begin
      send_item(OP_RX_BYTE, pick_line_char(plain), !plain && $urandom_range(0, 19) == 0,
                6'($urandom), 1'b1);
    end
    if (end_with_cr) send_item(OP_RX_BYTE, CH_CR, 1'b0, 6'($urandom), 1'b1);
    repeat ($urandom_range(0, 4)) begin
      send_item(OP_READ, 8'($urandom), 1'($urandom), 6'($urandom), 1'b1);
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    operation   <= OP_RX_BYTE;
    rx_byte     <= 8'h00;
    frame_error <= 1'b0;
    read_index  <= 6'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_READ, 8'h00, 1'b0, 6'd0, 1'b1);
    send_item(OP_READ, 8'hFF, 1'b1, 6'd63, 1'b1);
    send_item(OP_RX_BYTE, 8'h41, 1'b0, 6'd0, 1'b1);
    send_item(OP_UNUSED, 8'h00, 1'b0, 6'd0, 1'b1);
    send_item(OP_ARM, 8'h00, 1'b0, 6'd0, 1'b1);
    send_item(OP_RX_BYTE, CH_DELETE, 1'b0, 6'd0, 1'b1);
    send_item(OP_RX_BYTE, 8'hFF, 1'b1, 6'd0, 1'b1);
    send_item(OP_RX_BYTE, 8'h00, 1'b0, 6'd0, 1'b1);
    send_item(OP_RX_BYTE, 8'hFF, 1'b0, 6'd0, 1'b1);
    send_item(OP_RX_BYTE, CH_LF, 1'b0, 6'd0, 1'b1);
    send_item(OP_RX_BYTE, CH_DELETE, 1'b0, 6'd0, 1'b1);
    send_item(OP_RX_BYTE, 8'h41, 1'b0, 6'd0, 1'b1);
    send_item(OP_RX_BYTE, CH_CR, 1'b0, 6'd0, 1'b1);
    send_item(OP_RX_BYTE, 8'h42, 1'b0, 6'd0, 1'b1);
    send_item(OP_READ, 8'h00, 1'b0, 6'd0, 1'b1);
    send_item(OP_READ, 8'h00, 1'b0, 6'd1, 1'b1);
    send_item(OP_READ, 8'h00, 1'b0, 6'd2, 1'b1);
    send_item(OP_READ, 8'h00, 1'b0, 6'd3, 1'b1);
    send_item(OP_UNUSED, 8'hFF, 1'b1, 6'd63, 1'b1);

    // Lines that end exactly on the last entry, on a full store, and overflow.
    run_line_session(LINE_DEPTH - 1, 1'b1, 1'b1);
    run_line_session(LINE_DEPTH, 1'b1, 1'b1);
    run_line_session(LINE_DEPTH + 2, 1'b1, 1'b0);

    while (items_sent < TARGET_ITEMS) begin
      if (items_sent >= HOLD_AT_ITEM && !hold_done) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      if (items_sent >= QUIET_FROM_ITEM) begin
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
      end
      case ($urandom_range(0, 9))
        0:       line_length = $urandom_range(LINE_DEPTH - 2, LINE_DEPTH + 2);
        1:       line_length = 0;
        default: line_length = $urandom_range(1, 20);
      endcase
      run_line_session(line_length, $urandom_range(0, 3) == 0, $urandom_range(0, 4) != 0);
      if ($urandom_range(0, 3) == 0) begin
        send_item($urandom_range(0, 1) ? OP_UNUSED : OP_RX_BYTE, 8'($urandom), 1'($urandom),
                  6'($urandom), 1'b0);
      end
    end
    in_valid <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (STALL_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

@@ serial_line_input_assembler_top.f @@
design/sla_pkg.sv
design/sla_line_store.sv
design/sla_result_buffer.sv
design/serial_line_input_assembler_top.sv
tb/serial_line_input_assembler_checker.sv
tb/tb_serial_line_input_assembler_top.sv
